/* rtl/sgb_pkg.sv */
// Shared types, codes and constants of the separable smoothing block.
package sgb_pkg;

  localparam int GridZ      = 256;
  localparam int GridX      = 256;
  localparam int MaxRadius  = 31;
  localparam int TapCount   = 2 * MaxRadius + 1;
  localparam int SampleBits = 16;
  localparam int ZBits      = $clog2(GridZ);
  localparam int XBits      = $clog2(GridX);
  localparam int KBits      = $clog2(TapCount);
  localparam int AccBits    = 2 * SampleBits + KBits;

  typedef enum logic [1:0] {
    ACT_TAP_WR  = 2'd0,
    ACT_SMP_WR  = 2'd1,
    ACT_RUN     = 2'd2,
    ACT_READ    = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    CFG_RADIUS  = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_COLUMNS = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_MAC,
    ST_DRAIN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             tap_wr;
    logic             smp_wr;
    logic             rd_issue;
    logic             issue;
    logic             first;
    logic             pass;
    logic [XBits-1:0] ix;
    logic [ZBits-1:0] iz;
    logic [KBits-1:0] k;
    logic             wr_result;
    logic             clr_sat;
    logic             load_rd;
    logic             load_run;
  } cmd_t;

  typedef struct packed {
    logic [4:0] radius;
    logic [8:0] rows;
    logic [8:0] cols;
  } status_t;

endpackage

/* rtl/sgb_ctrl.sv */
// Controller state machine: sequences actions, passes and kernel taps.
module sgb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  sgb_pkg::status_t      status,
  output sgb_pkg::cmd_t         cmd
);

  sgb_pkg::state_t state_r, state_nxt;
  logic                       pass_r, pass_nxt;
  logic [sgb_pkg::XBits-1:0]  ix_r, ix_nxt;
  logic [sgb_pkg::ZBits-1:0]  iz_r, iz_nxt;
  logic [sgb_pkg::KBits-1:0]  k_r, k_nxt;
  logic [1:0]                 drain_r, drain_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [sgb_pkg::ZBits-1:0]  z_last;
  logic [sgb_pkg::XBits-1:0]  x_last;
  logic [sgb_pkg::KBits-1:0]  k_last;
  logic                       accept;

  assign z_last    = sgb_pkg::ZBits'(status.rows - 9'd1);
  assign x_last    = sgb_pkg::XBits'(status.cols - 9'd1);
  assign k_last    = sgb_pkg::KBits'({status.radius, 1'b0});
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sgb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      pass_r      <= 1'b0;
      ix_r        <= '0;
      iz_r        <= '0;
      k_r         <= '0;
      drain_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pass_r      <= pass_nxt;
      ix_r        <= ix_nxt;
      iz_r        <= iz_nxt;
      k_r         <= k_nxt;
      drain_r     <= drain_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    ix_nxt        = ix_r;
    iz_nxt        = iz_r;
    k_nxt         = k_r;
    drain_nxt     = drain_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    accept        = 1'b0;
    cmd           = '0;
    cmd.pass      = pass_r;
    cmd.ix        = ix_r;
    cmd.iz        = iz_r;
    cmd.k         = k_r;
    unique case (state_r)
      sgb_pkg::ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        accept   = in_valid && in_ready;
        if (accept) begin
          unique case (sgb_pkg::act_t'(in_action))
            sgb_pkg::ACT_TAP_WR: cmd.tap_wr = 1'b1;
            sgb_pkg::ACT_SMP_WR: cmd.smp_wr = 1'b1;
            sgb_pkg::ACT_RUN: begin
              cmd.clr_sat = 1'b1;
              pass_nxt    = 1'b0;
              ix_nxt      = '0;
              iz_nxt      = '0;
              k_nxt       = '0;
              state_nxt   = sgb_pkg::ST_MAC;
            end
            sgb_pkg::ACT_READ: begin
              cmd.rd_issue = 1'b1;
              state_nxt    = sgb_pkg::ST_RDWAIT;
            end
            default: ;
          endcase
        end
      end
      sgb_pkg::ST_RDWAIT: begin
        cmd.load_rd   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = sgb_pkg::ST_IDLE;
      end
      sgb_pkg::ST_MAC: begin
        cmd.issue = 1'b1;
        cmd.first = (k_r == '0);
        if (k_r == k_last) begin
          k_nxt     = '0;
          drain_nxt = '0;
          state_nxt = sgb_pkg::ST_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      sgb_pkg::ST_DRAIN: begin
        drain_nxt = drain_r + 2'd1;
        if (drain_r == 2'd1) begin
          state_nxt = sgb_pkg::ST_WRITE;
        end
      end
      sgb_pkg::ST_WRITE: begin
        cmd.wr_result = 1'b1;
        state_nxt     = sgb_pkg::ST_MAC;
        if (iz_r == z_last) begin
          iz_nxt = '0;
          if (ix_r == x_last) begin
            ix_nxt = '0;
            if (pass_r) begin
              state_nxt = sgb_pkg::ST_DONE;
            end else begin
              pass_nxt = 1'b1;
            end
          end else begin
            ix_nxt = ix_r + 1'b1;
          end
        end else begin
          iz_nxt = iz_r + 1'b1;
        end
      end
      sgb_pkg::ST_DONE: begin
        cmd.load_run  = 1'b1;
        out_valid_nxt = 1'b1;
        pass_nxt      = 1'b0;
        state_nxt     = sgb_pkg::ST_IDLE;
      end
      default: state_nxt = sgb_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/sgb_dp.sv */
// Datapath: configuration, tap and grid memories, clamped addressing and MAC.
module sgb_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [8:0]                     cfg_wdata,
  input  logic [5:0]                     in_tap_index,
  input  logic [15:0]                    in_tap_weight,
  input  logic [7:0]                     in_row_z,
  input  logic [7:0]                     in_column_x,
  input  logic [15:0]                    in_sample_value,
  input  sgb_pkg::cmd_t                  cmd,
  output sgb_pkg::status_t               status,
  output logic                           out_result_kind,
  output logic [15:0]                    out_result_value,
  output logic                           out_saturated
);

  localparam int AW = sgb_pkg::ZBits + sgb_pkg::XBits;
  localparam int SB = sgb_pkg::SampleBits;

  logic [SB-1:0] tap_mem  [sgb_pkg::TapCount];
  logic [SB-1:0] grid_mem [2**AW];
  logic [SB-1:0] pass_mem [2**AW];

  logic [4:0] radius_r;
  logic [8:0] rows_r, cols_r;
  logic       sat_r;

  logic [SB-1:0]              tap_q_r, src_q_r;
  logic [2*SB-1:0]            prod_r;
  logic [sgb_pkg::AccBits-1:0] acc_r;
  logic                       v1_r, v2_r, f1_r, f2_r;

  logic [sgb_pkg::ZBits-1:0] pos;
  logic [8:0]                lim;
  logic signed [9:0]         spos;
  logic [7:0]                cpos;
  logic [AW-1:0]             src_addr, dst_addr, grid_raddr;
  logic [sgb_pkg::AccBits-1:0] rnd;
  logic [sgb_pkg::AccBits-17:0] quo;
  logic                      sat;
  logic [SB-1:0]             res;

  always_comb begin
    status.radius = (radius_r == 5'd0) ? 5'd1 : radius_r;
    status.rows   = (rows_r == 9'd0) ? 9'd1 : ((rows_r > 9'd256) ? 9'd256 : rows_r);
    status.cols   = (cols_r == 9'd0) ? 9'd1 : ((cols_r > 9'd256) ? 9'd256 : cols_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 5'd1;
      rows_r   <= 9'd256;
      cols_r   <= 9'd256;
    end else if (cfg_we) begin
      case (sgb_pkg::cfg_idx_t'(cfg_index))
        sgb_pkg::CFG_RADIUS:  radius_r <= cfg_wdata[4:0];
        sgb_pkg::CFG_ROWS:    rows_r   <= cfg_wdata;
        sgb_pkg::CFG_COLUMNS: cols_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos  = cmd.pass ? cmd.ix : cmd.iz;
    lim  = cmd.pass ? status.cols : status.rows;
    spos = $signed({2'b00, pos}) + $signed({4'b0000, cmd.k})
         - $signed({5'b00000, status.radius});
    if (spos < 10'sd0) begin
      cpos = 8'd0;
    end else if (spos > $signed({1'b0, lim - 9'd1})) begin
      cpos = 8'(lim - 9'd1);
    end else begin
      cpos = spos[7:0];
    end
    src_addr   = cmd.pass ? {cmd.iz, cpos} : {cpos, cmd.ix};
    dst_addr   = {cmd.iz, cmd.ix};
    grid_raddr = cmd.rd_issue ? {in_row_z, in_column_x} : src_addr;
    rnd        = acc_r + sgb_pkg::AccBits'(32'h8000);
    quo        = rnd[sgb_pkg::AccBits-1:16];
    sat        = |quo[sgb_pkg::AccBits-17:SB];
    res        = sat ? {SB{1'b1}} : quo[SB-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.tap_wr && (in_tap_index < 6'(sgb_pkg::TapCount))) begin
      tap_mem[in_tap_index] <= in_tap_weight;
    end
    tap_q_r <= tap_mem[cmd.k];
  end

  always_ff @(posedge clk) begin
    if (cmd.smp_wr) begin
      grid_mem[{in_row_z, in_column_x}] <= in_sample_value;
    end else if (cmd.wr_result && cmd.pass) begin
      grid_mem[dst_addr] <= res;
    end
    if (cmd.pass) begin
      src_q_r <= pass_mem[src_addr];
    end else begin
      src_q_r <= grid_mem[grid_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_result && !cmd.pass) begin
      pass_mem[dst_addr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      sat_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.clr_sat) begin
        sat_r <= 1'b0;
      end else if (cmd.wr_result && sat) begin
        sat_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    f1_r   <= cmd.first;
    f2_r   <= f1_r;
    prod_r <= tap_q_r * src_q_r;
    if (v2_r) begin
      acc_r <= f2_r ? sgb_pkg::AccBits'(prod_r) : acc_r + sgb_pkg::AccBits'(prod_r);
    end
    if (cmd.load_rd) begin
      out_result_kind  <= 1'b1;
      out_result_value <= src_q_r;
      out_saturated    <= sat_r;
    end else if (cmd.load_run) begin
      out_result_kind  <= 1'b0;
      out_result_value <= '0;
      out_saturated    <= sat_r;
    end
  end

endmodule

/* rtl/separable_gaussian_blur_2d.sv */
// Top level of the separable smoothing block: controller plus datapath.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    action, tap, coordinate, sample
//   out_     output     out_valid/out_ready  result_kind, result_value, saturated
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// Tap and sample writes land on acceptance; a read passes the source and result
// registers. A run makes two passes over rows * columns outputs, one MAC per cycle
// outside the drain and write states, through the grid and pass memories' single read
// ports. Reset sets up the controller, the config registers and the saturation flag,
// not the memories. Input is held off while a result word waits and out_ready is low.
module separable_gaussian_blur_2d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [5:0]  in_tap_index,
  input  logic [15:0] in_tap_weight,
  input  logic [7:0]  in_row_z,
  input  logic [7:0]  in_column_x,
  input  logic [15:0] in_sample_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [15:0] out_result_value,
  output logic        out_saturated
);

  sgb_pkg::cmd_t    cmd;
  sgb_pkg::status_t status;

  sgb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sgb_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_tap_index     (in_tap_index),
    .in_tap_weight    (in_tap_weight),
    .in_row_z         (in_row_z),
    .in_column_x      (in_column_x),
    .in_sample_value  (in_sample_value),
    .cmd              (cmd),
    .status           (status),
    .out_result_kind  (out_result_kind),
    .out_result_value (out_result_value),
    .out_saturated    (out_saturated)
  );

endmodule
